FILE: sv/bec_pkg.sv
package bec_pkg;

  localparam int TABLE_SLOTS = 32;
  localparam int IDX_W       = $clog2(TABLE_SLOTS);
  localparam int ETA_W       = 16;
  localparam int RATIO_IN_W  = 16;
  localparam int MAG_W       = 14;
  localparam int RATIO_W     = 15;
  localparam int COEF_W      = 24;
  localparam int OUT_W       = 17;

  typedef logic [MAG_W-1:0]          mag_t;
  typedef logic [RATIO_W-1:0]        ratio_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic signed [COEF_W-1:0]  coef_t;

  typedef struct packed {
    idx_t idx;
    logic gap;
    logic none;
  } bin_sel_t;

  localparam logic [16:0] ETA_MIN_Q      = 17'd82;
  localparam mag_t        ETA_LOW_SUB_Q  = 14'd82;
  localparam logic [16:0] ETA_MAX_Q      = 17'd10240;
  localparam mag_t        ETA_HIGH_SUB_Q = 14'd10199;
  localparam logic [15:0] RATIO_MIN_Q    = 16'd3277;
  localparam logic [15:0] RATIO_MAX_Q    = 16'd20480;
  localparam ratio_t      RATIO_QUAD_Q   = 15'd4916;
  localparam logic [OUT_W-1:0] OUT_MAX   = 17'd131071;
  localparam logic [OUT_W-1:0] OUT_UNITY = 17'd65536;

  // Converts a decimal value given in units of 1e-9 to Q1.22, rounding half away from zero.
  function automatic coef_t q22(longint n);
    longint half;
    half = (n < 0) ? -longint'(500000000) : longint'(500000000);
    return coef_t'((n * 4194304 + half) / 1000000000);
  endfunction

  // Bin edges in Q2.12 units; |eta| >= edge is exact on the integer codes.
  localparam mag_t BIN_LO [TABLE_SLOTS] = '{
    0: 14'd82,   1: 14'd1024, 2: 14'd1885,  3: 14'd3318,  4: 14'd3728,
    5: 14'd4137, 6: 14'd4752, 7: 14'd6390,  8: 14'd6771,  9: 14'd7373,
    10: 14'd8192, 11: 14'd9012, 12: 14'd9421, 13: 14'd9831,
    default: '0
  };

  localparam mag_t BIN_HI [TABLE_SLOTS] = '{
    0: 14'd1024, 1: 14'd1721, 2: 14'd3154,  3: 14'd3728,  4: 14'd4137,
    5: 14'd4629, 6: 14'd5899, 7: 14'd6771,  8: 14'd7373,  9: 14'd8192,
    10: 14'd9012, 11: 14'd9421, 12: 14'd9831, 13: 14'd10240,
    default: '0
  };

  localparam coef_t FLAT_ROM [TABLE_SLOTS] = '{
    0: q22(1002270000), 1: q22(1002520000), 2: q22(1002250000), 3: q22(1001590000),
    4: q22(999475000),  5: q22(997203000),  6: q22(993886000),  7: q22(971262000),
    8: q22(975922000),  9: q22(979087000),  10: q22(984950000), 11: q22(987810000),
    12: q22(989546000), 13: q22(989638000),
    default: '0
  };

  localparam coef_t C0_ROM [TABLE_SLOTS] = '{
    0: q22(1007180000), 1: q22(1007130000), 2: q22(1006410000), 3: q22(1007610000),
    4: q22(1006820000), 5: q22(1007300000), 6: q22(1004620000), 7: q22(972798000),
    8: q22(981672000),  9: q22(982510000),  10: q22(986123000), 11: q22(990124000),
    12: q22(990187000), 13: q22(993720000),
    default: '0
  };

  localparam coef_t C1_ROM [TABLE_SLOTS] = '{
    0: q22(-1878860), 1: q22(-2275740), 2: q22(-2599350), 3: q22(-4336920),
    4: q22(-5513240), 5: q22(-7996690), 6: q22(-8700570), 7: q22(-771577),
    8: q22(-2020280), 9: q22(4413080),  10: q22(8329130), 11: q22(7428790),
    12: q22(9460800), 13: q22(5604060),
    default: '0
  };

  localparam coef_t C2_ROM [TABLE_SLOTS] = '{
    7: q22(-2766960),  8: q22(-4710280),  9: q22(-8091390), 10: q22(-9445840),
    11: q22(-9604620), 12: q22(-10172000), 13: q22(-9431690),
    default: '0
  };

endpackage

FILE: sv/bec_bin_select.sv
module bec_bin_select #(
  parameter int NUM_BINS = 14
) (
  input  bec_pkg::mag_t     mag_i,
  output bec_pkg::bin_sel_t sel_o
);

  logic [bec_pkg::TABLE_SLOTS-1:0] bin_hit;
  logic [bec_pkg::TABLE_SLOTS-1:0] gap_hit;
  bec_pkg::idx_t                   bin_idx;
  bec_pkg::idx_t                   gap_idx;

  always_comb begin
    bin_hit = '0;
    gap_hit = '0;
    for (int i = 0; i < NUM_BINS; i++) begin
      bin_hit[i] = (bec_pkg::BIN_LO[i] <= mag_i) && (mag_i < bec_pkg::BIN_HI[i]);
    end
    for (int i = 0; i + 1 < NUM_BINS; i++) begin
      gap_hit[i] = (bec_pkg::BIN_HI[i] <= mag_i) && (mag_i < bec_pkg::BIN_LO[i+1]);
    end
  end

  // Bins do not overlap and neither do gaps, so at most one hit of each kind
  // is set and the index can be formed by OR-ing.
  always_comb begin
    bin_idx = '0;
    gap_idx = '0;
    for (int i = 0; i < bec_pkg::TABLE_SLOTS; i++) begin
      bin_idx = bin_idx | (bin_hit[i] ? bec_pkg::IDX_W'(i) : '0);
      gap_idx = gap_idx | (gap_hit[i] ? bec_pkg::IDX_W'(i) : '0);
    end
    sel_o.idx  = (|bin_hit) ? bin_idx : gap_idx;
    sel_o.gap  = !(|bin_hit) && (|gap_hit);
    sel_o.none = !(|bin_hit) && !(|gap_hit);
  end

endmodule

FILE: sv/binned_eta_brem_correction.sv
// Binned eta / width-ratio correction. A fully pipelined datapath with six
// register stages: one item is taken on every cycle in which start_i is high
// (busy_o never rises), and its correction_factor_o appears with done_o high
// for one cycle once the item has passed all stages. The receiver cannot
// stall the block, so each result must be taken in the cycle its strobe is
// high. The stages are clamp, bin search with the ratio square, coefficient
// table read, the four coefficient products, the two bin sums, and the gap
// average with rounding and saturation. There is no state between items and
// no start-up sweep.
module binned_eta_brem_correction #(
  parameter int NUM_BINS = 14
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic signed [bec_pkg::ETA_W-1:0]     eta_value_i,
  input  logic [bec_pkg::RATIO_IN_W-1:0]       width_ratio_i,
  output logic                                 done_o,
  output logic [bec_pkg::OUT_W-1:0]            correction_factor_o
);

  localparam int P1_W  = bec_pkg::COEF_W + bec_pkg::RATIO_W + 1;
  localparam int RR_W  = 2 * bec_pkg::RATIO_W - 1;
  localparam int P2_W  = bec_pkg::COEF_W + RR_W + 1;
  localparam int ACC_W = 56;

  // Stage 1: clamp.
  logic [16:0]       eta_ext;
  logic [16:0]       eta_mag;
  bec_pkg::mag_t     mag_d, mag_q;
  logic [15:0]       ratio_lim;
  bec_pkg::ratio_t   r1_q;
  logic              quad1_q;
  logic              v1_q;

  // Stage 2: bin search and ratio square.
  bec_pkg::bin_sel_t sel_d, sel2_q;
  bec_pkg::ratio_t   r2_q;
  logic [RR_W-1:0]   rr2_q;
  logic              quad2_q;
  logic              v2_q;

  // Stage 3: coefficients of the bin and of its upper neighbor.
  bec_pkg::idx_t     idx_b;
  bec_pkg::coef_t    k0a_q, k1a_q, k2a_q, k0b_q, k1b_q, k2b_q;
  bec_pkg::ratio_t   r3_q;
  logic [RR_W-1:0]   rr3_q;
  logic              gap3_q, none3_q, v3_q;

  // Stage 4: products.
  logic signed [P1_W-1:0]  p1a_q, p1b_q;
  logic signed [P2_W-1:0]  p2a_q, p2b_q;
  bec_pkg::coef_t          k0a4_q, k0b4_q;
  logic                    gap4_q, none4_q, v4_q;

  // Stage 5: bin values in Q46.
  logic signed [ACC_W-1:0] va_q, vb_q;
  logic                    gap5_q, none5_q, v5_q;

  // Stage 6: output.
  logic signed [ACC_W-1:0] sum;
  logic signed [ACC_W-1:0] rounded;
  logic [bec_pkg::OUT_W-1:0] result_d, result_q;
  logic                    v6_q;

  assign busy_o = 1'b0;

  always_comb begin
    eta_ext = {eta_value_i[bec_pkg::ETA_W-1], eta_value_i};
    eta_mag = eta_value_i[bec_pkg::ETA_W-1] ? (~eta_ext + 17'd1) : eta_ext;
    if (eta_mag < bec_pkg::ETA_MIN_Q) begin
      mag_d = bec_pkg::ETA_LOW_SUB_Q;
    end else if (eta_mag >= bec_pkg::ETA_MAX_Q) begin
      mag_d = bec_pkg::ETA_HIGH_SUB_Q;
    end else begin
      mag_d = eta_mag[bec_pkg::MAG_W-1:0];
    end
    if (width_ratio_i < bec_pkg::RATIO_MIN_Q) begin
      ratio_lim = bec_pkg::RATIO_MIN_Q;
    end else if (width_ratio_i > bec_pkg::RATIO_MAX_Q) begin
      ratio_lim = bec_pkg::RATIO_MAX_Q;
    end else begin
      ratio_lim = width_ratio_i;
    end
  end

  bec_bin_select #(
    .NUM_BINS(NUM_BINS)
  ) u_bin_select (
    .mag_i(mag_q),
    .sel_o(sel_d)
  );

  assign idx_b = sel2_q.idx + bec_pkg::IDX_W'(1);

  always_comb begin
    // A gap sums both neighbors; a bin doubles its own value so that both
    // cases round with the same shift.
    sum = gap5_q ? (va_q + vb_q) : (va_q <<< 1);
    rounded = (sum + (ACC_W'(1) <<< 30)) >>> 31;
    if (none5_q) begin
      result_d = bec_pkg::OUT_UNITY;
    end else if (sum <= 0) begin
      result_d = '0;
    end else if (rounded > ACC_W'(bec_pkg::OUT_MAX)) begin
      result_d = bec_pkg::OUT_MAX;
    end else begin
      result_d = rounded[bec_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      v1_q <= start_i && !busy_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    r1_q    <= ratio_lim[bec_pkg::RATIO_W-1:0];
    quad1_q <= ratio_lim[bec_pkg::RATIO_W-1:0] >= bec_pkg::RATIO_QUAD_Q;

    sel2_q  <= sel_d;
    r2_q    <= r1_q;
    rr2_q   <= RR_W'(r1_q) * RR_W'(r1_q);
    quad2_q <= quad1_q;

    k0a_q   <= quad2_q ? bec_pkg::C0_ROM[sel2_q.idx] : bec_pkg::FLAT_ROM[sel2_q.idx];
    k1a_q   <= quad2_q ? bec_pkg::C1_ROM[sel2_q.idx] : '0;
    k2a_q   <= quad2_q ? bec_pkg::C2_ROM[sel2_q.idx] : '0;
    k0b_q   <= quad2_q ? bec_pkg::C0_ROM[idx_b] : bec_pkg::FLAT_ROM[idx_b];
    k1b_q   <= quad2_q ? bec_pkg::C1_ROM[idx_b] : '0;
    k2b_q   <= quad2_q ? bec_pkg::C2_ROM[idx_b] : '0;
    r3_q    <= r2_q;
    rr3_q   <= rr2_q;
    gap3_q  <= sel2_q.gap;
    none3_q <= sel2_q.none;

    p1a_q   <= k1a_q * $signed({1'b0, r3_q});
    p1b_q   <= k1b_q * $signed({1'b0, r3_q});
    p2a_q   <= k2a_q * $signed({1'b0, rr3_q});
    p2b_q   <= k2b_q * $signed({1'b0, rr3_q});
    k0a4_q  <= k0a_q;
    k0b4_q  <= k0b_q;
    gap4_q  <= gap3_q;
    none4_q <= none3_q;

    va_q    <= (ACC_W'(k0a4_q) <<< 24) + (ACC_W'(p1a_q) <<< 12) + ACC_W'(p2a_q);
    vb_q    <= (ACC_W'(k0b4_q) <<< 24) + (ACC_W'(p1b_q) <<< 12) + ACC_W'(p2b_q);
    gap5_q  <= gap4_q;
    none5_q <= none4_q;

    result_q <= result_d;
  end

  assign done_o              = v6_q;
  assign correction_factor_o = result_q;

  a_start_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##6 done_o)
    else $error("accepted item did not complete after six cycles");

  a_done_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 6))
    else $error("result strobe without a matching transfer");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !sel2_q.none) |-> (sel2_q.idx < NUM_BINS))
    else $error("bin index beyond the configured bin count");

  a_gap_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> !(gap3_q && none3_q))
    else $error("item flagged both as gap and as outside all bins");

endmodule
